[hw/rtl/birm_pkg.sv]
`default_nettype none

package birm_pkg;

	localparam int RING_DEPTH = 128;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam int REG_W  = 24;
	localparam int SIDX_W = 31;
	localparam int DIFF_W = SIDX_W + 1;
	localparam int BPM_W  = 16;

	// sum of kept intervals stays below window + one interval
	localparam int SUM_W     = REG_W + 1;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [REG_W-1:0] WINDOW_RESET   = REG_W'(264600);
	localparam logic [REG_W-1:0] DEAD_RESET     = REG_W'(8820);
	localparam logic [REG_W-1:0] MAX_GAP_RESET  = REG_W'(110250);
	localparam logic [REG_W-1:0] SPM_RESET      = REG_W'(2646000);
	localparam logic [BPM_W-1:0] BPM_MAX        = '1;

	localparam logic MODE_BEAT    = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	typedef enum logic [1:0] {
		REG_WINDOW  = 2'd0,
		REG_DEAD    = 2'd1,
		REG_MAX_GAP = 2'd2,
		REG_SPM     = 2'd3
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FULL_FETCH,
		S_FULL_DROP,
		S_PUSH,
		S_TRIM_CHK,
		S_TRIM_FETCH,
		S_TRIM_DROP,
		S_DIV_MEAN,
		S_DIV_RATE,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/beat_interval_rate_meter_unit.sv]
`default_nettype none

// Heart rate meter over a sliding window of beat-to-beat intervals. Each input beat
// carries the sample index of a detected beat (mode 0) or restarts the meter (mode 1).
// Intervals live in a ring memory of RING_DEPTH entries with one synchronous read port;
// no clearing pass is needed after reset, the fill count guards every read. A beat
// inside the dead period yields nothing. A restart or a re-anchor after a too-long gap
// reports 0, as does the first interval. Otherwise an item is pushed into the ring,
// then old intervals are trimmed from the window (each trim is one ring read and a
// subtract), then the two 25-step restoring divisions (mean interval, then rate)
// share one divider. A full ring first drops its oldest entry the same way; a zero
// mean skips the rate division. A finished rate waits in an output register, so the
// next beat can be taken before it is collected; another result stalls until that
// register frees.
module beat_interval_rate_meter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [birm_pkg::REG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           mode,
	input  wire logic [birm_pkg::SIDX_W-1:0]    sample_index,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [birm_pkg::BPM_W-1:0]          beats_per_minute
);

	localparam int IDX_W  = birm_pkg::IDX_W;
	localparam int CNT_W  = birm_pkg::CNT_W;
	localparam int REG_W  = birm_pkg::REG_W;
	localparam int SIDX_W = birm_pkg::SIDX_W;
	localparam int DIFF_W = birm_pkg::DIFF_W;
	localparam int BPM_W  = birm_pkg::BPM_W;
	localparam int SUM_W  = birm_pkg::SUM_W;
	localparam int STEP_W = birm_pkg::STEP_W;
	localparam int DEPTH  = birm_pkg::RING_DEPTH;

	birm_pkg::state_t state_q, state_d;

	logic [REG_W-1:0] win_q, dead_q, gap_max_q, spm_q;

	logic [REG_W-1:0] ring_mem [DEPTH];
	logic [REG_W-1:0] rd_data_q;

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SIDX_W-1:0] prev_q;
	logic [REG_W-1:0]  gap_q;

	logic [SUM_W-1:0]  dvd_q;
	logic [REG_W-1:0]  rem_q, dvs_q;
	logic [STEP_W-1:0] step_q;

	logic [BPM_W-1:0] res_q, bpm_q;
	logic             out_valid_q;

	logic              accept, mem_we, out_free, load_out;
	logic [DIFF_W-1:0] diff;
	logic              beat_early, beat_late, ring_full, trim_need;
	logic [IDX_W-1:0]  head_inc, slot;
	logic [IDX_W:0]    slot_wide;
	logic [REG_W:0]    rem_sh, rem_nx;
	logic              q_bit, div_last, mean_zero, rate_sat;
	logic [SUM_W-1:0]  dvd_nx;

	assign diff = {1'b0, sample_index} - {1'b0, prev_q};
	assign beat_early = diff[DIFF_W-1]
		|| (diff[SIDX_W-1:0] < {{(SIDX_W-REG_W){1'b0}}, dead_q});
	assign beat_late = !diff[DIFF_W-1]
		&& (diff[SIDX_W-1:0] > {{(SIDX_W-REG_W){1'b0}}, gap_max_q});

	assign ring_full = (count_q == CNT_W'(DEPTH));
	assign head_inc  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign slot_wide = {1'b0, head_q} + {1'b0, count_q[IDX_W-1:0]};
	assign slot      = (slot_wide >= (IDX_W+1)'(DEPTH)) ?
		IDX_W'(slot_wide - (IDX_W+1)'(DEPTH)) : slot_wide[IDX_W-1:0];
	assign trim_need = (sum_q > {1'b0, win_q}) && (count_q > CNT_W'(1));

	// restoring divider, one quotient bit per cycle
	assign rem_sh    = {rem_q, dvd_q[SUM_W-1]};
	assign q_bit     = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx    = q_bit ? rem_sh - {1'b0, dvs_q} : rem_sh;
	assign dvd_nx    = {dvd_q[SUM_W-2:0], q_bit};
	assign div_last  = (step_q == STEP_W'(birm_pkg::DIV_STEPS - 1));
	assign mean_zero = (dvd_nx[REG_W-1:0] == '0);
	assign rate_sat  = (dvd_nx[SUM_W-1:BPM_W] != '0);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			birm_pkg::S_IDLE: begin
				if (in_valid) begin
					if (mode == birm_pkg::MODE_RESTART || (!beat_early && beat_late))
						state_d = birm_pkg::S_EMIT;
					else if (!beat_early)
						state_d = ring_full ? birm_pkg::S_FULL_FETCH : birm_pkg::S_PUSH;
				end
			end
			birm_pkg::S_FULL_FETCH: state_d = birm_pkg::S_FULL_DROP;
			birm_pkg::S_FULL_DROP:  state_d = birm_pkg::S_PUSH;
			birm_pkg::S_PUSH: begin
				state_d = (count_q == '0) ? birm_pkg::S_EMIT : birm_pkg::S_TRIM_CHK;
			end
			birm_pkg::S_TRIM_CHK: begin
				state_d = trim_need ? birm_pkg::S_TRIM_FETCH : birm_pkg::S_DIV_MEAN;
			end
			birm_pkg::S_TRIM_FETCH: state_d = birm_pkg::S_TRIM_DROP;
			birm_pkg::S_TRIM_DROP:  state_d = birm_pkg::S_TRIM_CHK;
			birm_pkg::S_DIV_MEAN: begin
				if (div_last)
					state_d = mean_zero ? birm_pkg::S_EMIT : birm_pkg::S_DIV_RATE;
			end
			birm_pkg::S_DIV_RATE: begin
				if (div_last)
					state_d = birm_pkg::S_EMIT;
			end
			birm_pkg::S_EMIT: begin
				if (out_free)
					state_d = birm_pkg::S_IDLE;
			end
			default: state_d = birm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == birm_pkg::S_IDLE);
		accept   = in_valid && in_ready;
		mem_we   = (state_q == birm_pkg::S_PUSH);
		load_out = (state_q == birm_pkg::S_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= birm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= birm_pkg::WINDOW_RESET;
			dead_q    <= birm_pkg::DEAD_RESET;
			gap_max_q <= birm_pkg::MAX_GAP_RESET;
			spm_q     <= birm_pkg::SPM_RESET;
		end else if (cfg_we) begin
			case (birm_pkg::reg_index_t'(cfg_index))
				birm_pkg::REG_WINDOW:  win_q     <= cfg_data;
				birm_pkg::REG_DEAD:    dead_q    <= cfg_data;
				birm_pkg::REG_MAX_GAP: gap_max_q <= cfg_data;
				birm_pkg::REG_SPM:     spm_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[slot] <= gap_q;
		rd_data_q <= ring_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
		end else begin
			case (state_q)
				birm_pkg::S_IDLE: begin
					if (accept) begin
						if (mode == birm_pkg::MODE_RESTART) begin
							head_q  <= '0;
							count_q <= '0;
							sum_q   <= '0;
							prev_q  <= '0;
						end else if (!beat_early) begin
							prev_q <= sample_index;
							if (beat_late) begin
								head_q  <= '0;
								count_q <= '0;
								sum_q   <= '0;
							end
						end
					end
				end
				birm_pkg::S_FULL_DROP, birm_pkg::S_TRIM_DROP: begin
					sum_q   <= sum_q - {1'b0, rd_data_q};
					head_q  <= head_inc;
					count_q <= count_q - 1'b1;
				end
				birm_pkg::S_PUSH: begin
					sum_q   <= sum_q + {1'b0, gap_q};
					count_q <= count_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			birm_pkg::S_IDLE: begin
				gap_q <= diff[REG_W-1:0];
				res_q <= '0;
			end
			birm_pkg::S_TRIM_CHK: begin
				dvd_q  <= sum_q;
				dvs_q  <= {{(REG_W-CNT_W){1'b0}}, count_q};
				rem_q  <= '0;
				step_q <= '0;
			end
			birm_pkg::S_DIV_MEAN: begin
				if (div_last) begin
					dvd_q  <= {1'b0, spm_q};
					dvs_q  <= dvd_nx[REG_W-1:0];
					rem_q  <= '0;
					step_q <= '0;
					res_q  <= birm_pkg::BPM_MAX;
				end else begin
					dvd_q  <= dvd_nx;
					rem_q  <= rem_nx[REG_W-1:0];
					step_q <= step_q + 1'b1;
				end
			end
			birm_pkg::S_DIV_RATE: begin
				dvd_q  <= dvd_nx;
				rem_q  <= rem_nx[REG_W-1:0];
				step_q <= step_q + 1'b1;
				if (div_last)
					res_q <= rate_sat ? birm_pkg::BPM_MAX : dvd_nx[BPM_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			bpm_q <= res_q;
	end

	assign out_valid        = out_valid_q;
	assign beats_per_minute = bpm_q;

endmodule

`default_nettype wire
